@@ rtl/radix_text_number_codec_assert.svh @@
// Assertion macros shared by the codec modules.
// RTNC_ASSERT_IMPL checks cons in the same cycle as ante.
// RTNC_ASSERT_NEXT checks cons in the cycle after ante.
`ifndef RADIX_TEXT_NUMBER_CODEC_ASSERT_SVH
`define RADIX_TEXT_NUMBER_CODEC_ASSERT_SVH

`ifndef ASSERT_OFF
`define RTNC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");
`define RTNC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");
`else
`define RTNC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RTNC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/rtnc_pkg.sv @@
package rtnc_pkg;

   localparam int DATA_WIDTH      = 64;
   localparam int SYMBOL_WIDTH    = 8;
   localparam int DIGIT_WIDTH     = 7;
   localparam int CHUNK_WIDTH     = 8;
   localparam int MUL_WIDTH       = DIGIT_WIDTH + CHUNK_WIDTH;
   localparam int MAX_DIGITS      = 11;
   localparam int DIGIT_IDX_WIDTH = $clog2(MAX_DIGITS);

   localparam int RADIX_LO    = 71;
   localparam int RADIX_HI    = 75;
   // reciprocals ceil(2^RECIP_SHIFT / radix), exact for dividends below 75*256
   localparam int RECIP_SHIFT = 21;
   localparam int RECIP_LO    = 29538;
   localparam int RECIP_HI    = 27963;

   localparam logic RADIX_SEL_71 = 1'b0;
   localparam logic RADIX_SEL_75 = 1'b1;

   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   typedef struct packed {
      logic                    mode;
      logic                    radix_sel;
      logic [DIGIT_WIDTH-1:0]  carry;
      logic [CHUNK_WIDTH-1:0]  chunk;
   } step_req_type;

   typedef struct packed {
      logic [CHUNK_WIDTH-1:0]  chunk;
      logic [DIGIT_WIDTH-1:0]  carry;
   } step_rsp_type;

   typedef struct packed {
      logic                    valid;
      logic [DIGIT_WIDTH-1:0]  value;
   } digit_type;

   function automatic logic [SYMBOL_WIDTH-1:0] digit_char(
      input logic sel, input logic [DIGIT_WIDTH-1:0] v);
      logic [SYMBOL_WIDTH-1:0] c;
      c = '0;
      if (sel == RADIX_SEL_71) begin
         if (v < 7'd10)      c = 8'h30 + 8'(v);
         else if (v < 7'd36) c = 8'h61 + 8'(v - 7'd10);
         else if (v < 7'd62) c = 8'h41 + 8'(v - 7'd36);
         else begin
            case (v)
               7'd62:   c = 8'h21;
               7'd63:   c = 8'h40;
               7'd64:   c = 8'h24;
               7'd65:   c = 8'h25;
               7'd66:   c = 8'h3f;
               7'd67:   c = 8'h26;
               7'd68:   c = 8'h3c;
               7'd69:   c = 8'h28;
               default: c = 8'h29;
            endcase
         end
      end else begin
         if (v < 7'd26)      c = 8'h61 + 8'(v);
         else if (v < 7'd52) c = 8'h41 + 8'(v - 7'd26);
         else begin
            case (v)
               7'd52:   c = 8'h21;
               7'd53:   c = 8'h40;
               7'd54:   c = 8'h23;
               7'd55:   c = 8'h24;
               7'd56:   c = 8'h25;
               7'd57:   c = 8'h3f;
               7'd58:   c = 8'h26;
               7'd59:   c = 8'h3c;
               7'd60:   c = 8'h3e;
               7'd61:   c = 8'h28;
               7'd62:   c = 8'h29;
               7'd63:   c = 8'h2b;
               7'd64:   c = 8'h5f;
               7'd65:   c = 8'h2a;
               7'd66:   c = 8'h7b;
               7'd67:   c = 8'h7d;
               7'd68:   c = 8'h5b;
               7'd69:   c = 8'h5d;
               7'd70:   c = 8'h7e;
               7'd71:   c = 8'h60;
               7'd72:   c = 8'h27;
               7'd73:   c = 8'h22;
               default: c = 8'h7c;
            endcase
         end
      end
      return c;
   endfunction

   function automatic digit_type digit_of(
      input logic sel, input logic [SYMBOL_WIDTH-1:0] ch);
      digit_type d;
      d.valid = 1'b1;
      d.value = '0;
      if (sel == RADIX_SEL_71) begin
         if (ch >= 8'h30 && ch <= 8'h39)      d.value = 7'(ch - 8'h30);
         else if (ch >= 8'h61 && ch <= 8'h7a) d.value = 7'(ch - 8'h61 + 8'd10);
         else if (ch >= 8'h41 && ch <= 8'h5a) d.value = 7'(ch - 8'h41 + 8'd36);
         else begin
            case (ch)
               8'h21:   d.value = 7'd62;
               8'h40:   d.value = 7'd63;
               8'h24:   d.value = 7'd64;
               8'h25:   d.value = 7'd65;
               8'h3f:   d.value = 7'd66;
               8'h26:   d.value = 7'd67;
               8'h3c:   d.value = 7'd68;
               8'h28:   d.value = 7'd69;
               8'h29:   d.value = 7'd70;
               default: d.valid = 1'b0;
            endcase
         end
      end else begin
         if (ch >= 8'h61 && ch <= 8'h7a)      d.value = 7'(ch - 8'h61);
         else if (ch >= 8'h41 && ch <= 8'h5a) d.value = 7'(ch - 8'h41 + 8'd26);
         else begin
            case (ch)
               8'h21:   d.value = 7'd52;
               8'h40:   d.value = 7'd53;
               8'h23:   d.value = 7'd54;
               8'h24:   d.value = 7'd55;
               8'h25:   d.value = 7'd56;
               8'h3f:   d.value = 7'd57;
               8'h26:   d.value = 7'd58;
               8'h3c:   d.value = 7'd59;
               8'h3e:   d.value = 7'd60;
               8'h28:   d.value = 7'd61;
               8'h29:   d.value = 7'd62;
               8'h2b:   d.value = 7'd63;
               8'h5f:   d.value = 7'd64;
               8'h2a:   d.value = 7'd65;
               8'h7b:   d.value = 7'd66;
               8'h7d:   d.value = 7'd67;
               8'h5b:   d.value = 7'd68;
               8'h5d:   d.value = 7'd69;
               8'h7e:   d.value = 7'd70;
               8'h60:   d.value = 7'd71;
               8'h27:   d.value = 7'd72;
               8'h22:   d.value = 7'd73;
               8'h7c:   d.value = 7'd74;
               default: d.valid = 1'b0;
            endcase
         end
      end
      return d;
   endfunction

endpackage

@@ rtl/rtnc_step.sv @@
module rtnc_step (
   input  rtnc_pkg::step_req_type step_req,
   output rtnc_pkg::step_rsp_type step_rsp
);
   import rtnc_pkg::*;

   logic [MUL_WIDTH-1:0]   radix;
   logic [MUL_WIDTH-1:0]   recip;
   logic [MUL_WIDTH-1:0]   dividend;
   logic [MUL_WIDTH-1:0]   mul_a;
   logic [MUL_WIDTH-1:0]   mul_b;
   logic [2*MUL_WIDTH-1:0] prod;
   logic [MUL_WIDTH-1:0]   quot;
   logic [MUL_WIDTH-1:0]   quot_times_radix;
   logic [MUL_WIDTH-1:0]   rem;
   logic [MUL_WIDTH-1:0]   mac;

   always_comb begin
      radix    = (step_req.radix_sel == RADIX_SEL_75) ? MUL_WIDTH'(RADIX_HI)
                                                       : MUL_WIDTH'(RADIX_LO);
      recip    = (step_req.radix_sel == RADIX_SEL_75) ? MUL_WIDTH'(RECIP_HI)
                                                       : MUL_WIDTH'(RECIP_LO);
      dividend = {step_req.carry, step_req.chunk};

      // one multiplier: reciprocal product for divide, chunk times radix for decode
      if (step_req.mode == OP_ENCODE) begin
         mul_a = dividend;
         mul_b = recip;
      end else begin
         mul_a = MUL_WIDTH'(step_req.chunk);
         mul_b = radix;
      end
      prod = (2*MUL_WIDTH)'(mul_a) * (2*MUL_WIDTH)'(mul_b);

      quot = MUL_WIDTH'(prod[RECIP_SHIFT +: CHUNK_WIDTH]);
      // radix 71 = 64 + 8 - 1, radix 75 = 64 + 8 + 2 + 1
      if (step_req.radix_sel == RADIX_SEL_75)
         quot_times_radix = (quot << 6) + (quot << 3) + (quot << 1) + quot;
      else
         quot_times_radix = (quot << 6) + (quot << 3) - quot;
      rem = dividend - quot_times_radix;

      mac = prod[MUL_WIDTH-1:0] + MUL_WIDTH'(step_req.carry);

      if (step_req.mode == OP_ENCODE) begin
         step_rsp.chunk = quot[CHUNK_WIDTH-1:0];
         step_rsp.carry = rem[DIGIT_WIDTH-1:0];
      end else begin
         step_rsp.chunk = mac[CHUNK_WIDTH-1:0];
         step_rsp.carry = mac[MUL_WIDTH-1:CHUNK_WIDTH];
      end
   end

endmodule

@@ rtl/radix_text_number_codec.sv @@
// Radix 71 / radix 75 text codec for unsigned numbers.
// Input beats (req_*) carry an operation: encode takes req_data as a number and
// returns 1 to 11 character beats on rsp_*, most significant first, with
// rsp_last_result on the final one. Decode takes one character in req_data[7:0];
// only a beat with req_last returns a beat, holding the accumulated value on
// rsp_number, rsp_is_number high and the sticky invalid-character flag.
// csr_write_enable / csr_write_data select the alphabet (0 = radix 71).
// The block works on one request at a time; req_ready is high only when idle.
// Work runs through one 8-bit step unit, one chunk of the number per cycle,
// C = ceil(NUMBER_WIDTH/8) chunks (8 at 64 bits):
//   encode: a divide pass per digit (D digits), then D character beats
//   decode: a multiply pass per character, then a result beat on the last.
// Each digit of an encode costs one full pass of the divide-by-radix loop.
// A result sits in an output register; a stalled receiver holds the
// sequencer in its emit state, while a new request is taken once idle.
// Reset (synchronous) clears the accumulator, error flag, radix select
// and any pending result.
`include "radix_text_number_codec_assert.svh"

module radix_text_number_codec #(
   parameter int NUMBER_WIDTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_operation,
   input  logic [rtnc_pkg::DATA_WIDTH-1:0]   req_data,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rtnc_pkg::SYMBOL_WIDTH-1:0] rsp_symbol,
   output logic [rtnc_pkg::DATA_WIDTH-1:0]   rsp_number,
   output logic                              rsp_is_number,
   output logic                              rsp_error,
   output logic                              rsp_last_result,
   input  logic                              csr_write_enable,
   input  logic                              csr_write_data
);
   import rtnc_pkg::*;

   localparam int CHUNKS = (NUMBER_WIDTH + CHUNK_WIDTH - 1) / CHUNK_WIDTH;
   localparam int PADW   = CHUNKS * CHUNK_WIDTH;
   localparam int CNT_W  = $clog2(CHUNKS);
   localparam logic [PADW-1:0] PAD_MASK = {PADW{1'b1}} >> (PADW - NUMBER_WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ENC_DIV,
      ST_ENC_OUT,
      ST_DEC_MUL,
      ST_DEC_OUT
   } state_type;

   state_type                   state_ff;
   logic                        radix_sel_ff;
   logic [PADW-1:0]             val_ff;
   logic [PADW-1:0]             acc_ff;
   logic                        err_ff;
   logic                        last_ff;
   logic [DIGIT_WIDTH-1:0]      carry_ff;
   logic                        nz_ff;
   logic [CNT_W-1:0]            chunk_cnt_ff;
   logic [DIGIT_IDX_WIDTH-1:0]  digit_cnt_ff;
   logic [DIGIT_IDX_WIDTH-1:0]  out_idx_ff;
   logic [SYMBOL_WIDTH-1:0]     digit_buf_ff [MAX_DIGITS];

   logic                        rsp_valid_ff;
   logic [SYMBOL_WIDTH-1:0]     rsp_symbol_ff;
   logic [DATA_WIDTH-1:0]       rsp_number_ff;
   logic                        rsp_is_number_ff;
   logic                        rsp_error_ff;
   logic                        rsp_last_result_ff;

   step_req_type                step_req;
   step_rsp_type                step_rsp;
   digit_type                   req_digit;
   logic [PADW-1:0]             acc_in;
   logic                        nz_in;
   logic                        slot_free;
   logic                        rsp_load;
   logic                        chunk_done;
   logic [DIGIT_WIDTH-1:0]      radix_val;

   rtnc_step u_step (
      .step_req (step_req),
      .step_rsp (step_rsp)
   );

   always_comb begin
      step_req.mode      = (state_ff == ST_DEC_MUL) ? OP_DECODE : OP_ENCODE;
      step_req.radix_sel = radix_sel_ff;
      step_req.carry     = carry_ff;
      step_req.chunk     = (state_ff == ST_DEC_MUL) ? acc_ff[CHUNK_WIDTH-1:0]
                                                    : val_ff[PADW-1 -: CHUNK_WIDTH];
      req_digit  = digit_of(radix_sel_ff, req_data[SYMBOL_WIDTH-1:0]);
      acc_in     = {step_rsp.chunk, acc_ff[PADW-1:CHUNK_WIDTH]};
      nz_in      = nz_ff | (step_rsp.chunk != '0);
      slot_free  = !rsp_valid_ff || rsp_ready;
      rsp_load   = ((state_ff == ST_ENC_OUT) || (state_ff == ST_DEC_OUT)) && slot_free;
      chunk_done = (chunk_cnt_ff == CNT_W'(CHUNKS - 1));
      radix_val  = (radix_sel_ff == RADIX_SEL_75) ? DIGIT_WIDTH'(RADIX_HI)
                                                  : DIGIT_WIDTH'(RADIX_LO);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         radix_sel_ff <= RADIX_SEL_71;
         acc_ff       <= '0;
         err_ff       <= 1'b0;
      end else begin
         if (csr_write_enable) radix_sel_ff <= csr_write_data;
         // load a new beat, or drop the one just taken
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  chunk_cnt_ff <= '0;
                  if (req_operation == OP_ENCODE) begin
                     val_ff       <= PADW'(req_data[NUMBER_WIDTH-1:0]);
                     carry_ff     <= '0;
                     nz_ff        <= 1'b0;
                     digit_cnt_ff <= '0;
                     state_ff     <= ST_ENC_DIV;
                  end else begin
                     // invalid character counts as digit zero
                     carry_ff <= req_digit.valid ? req_digit.value : '0;
                     err_ff   <= err_ff | !req_digit.valid;
                     last_ff  <= req_last;
                     state_ff <= ST_DEC_MUL;
                  end
               end
            end

            ST_ENC_DIV: begin
               // shift the quotient in behind the chunk just consumed
               val_ff <= {val_ff[PADW-CHUNK_WIDTH-1:0], step_rsp.chunk};
               if (chunk_done) begin
                  digit_buf_ff[digit_cnt_ff] <= digit_char(radix_sel_ff, step_rsp.carry);
                  carry_ff     <= '0;
                  nz_ff        <= 1'b0;
                  chunk_cnt_ff <= '0;
                  digit_cnt_ff <= digit_cnt_ff + DIGIT_IDX_WIDTH'(1);
                  if (!nz_in || digit_cnt_ff == DIGIT_IDX_WIDTH'(MAX_DIGITS - 1)) begin
                     out_idx_ff <= digit_cnt_ff;
                     state_ff   <= ST_ENC_OUT;
                  end
               end else begin
                  carry_ff     <= step_rsp.carry;
                  nz_ff        <= nz_in;
                  chunk_cnt_ff <= chunk_cnt_ff + CNT_W'(1);
               end
            end

            ST_ENC_OUT: begin
               if (slot_free) begin
                  rsp_symbol_ff      <= digit_buf_ff[out_idx_ff];
                  rsp_number_ff      <= '0;
                  rsp_is_number_ff   <= 1'b0;
                  rsp_error_ff       <= 1'b0;
                  rsp_last_result_ff <= (out_idx_ff == '0);
                  out_idx_ff         <= out_idx_ff - DIGIT_IDX_WIDTH'(1);
                  if (out_idx_ff == '0) state_ff <= ST_IDLE;
               end
            end

            ST_DEC_MUL: begin
               // rotate acc * radix in from the low chunk up; carry starts as the digit
               carry_ff <= step_rsp.carry;
               if (chunk_done) begin
                  acc_ff       <= acc_in & PAD_MASK;
                  chunk_cnt_ff <= '0;
                  state_ff     <= last_ff ? ST_DEC_OUT : ST_IDLE;
               end else begin
                  acc_ff       <= acc_in;
                  chunk_cnt_ff <= chunk_cnt_ff + CNT_W'(1);
               end
            end

            ST_DEC_OUT: begin
               if (slot_free) begin
                  rsp_symbol_ff      <= '0;
                  rsp_number_ff      <= DATA_WIDTH'(acc_ff[NUMBER_WIDTH-1:0]);
                  rsp_is_number_ff   <= 1'b1;
                  rsp_error_ff       <= err_ff;
                  rsp_last_result_ff <= 1'b1;
                  acc_ff             <= '0;
                  err_ff             <= 1'b0;
                  state_ff           <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_symbol      = rsp_symbol_ff;
   assign rsp_number      = rsp_number_ff;
   assign rsp_is_number   = rsp_is_number_ff;
   assign rsp_error       = rsp_error_ff;
   assign rsp_last_result = rsp_last_result_ff;

   `RTNC_ASSERT_NEXT(a_busy_after_accept, clock, reset,
      req_valid && req_ready, !req_ready)
   `RTNC_ASSERT_IMPL(a_carry_below_radix, clock, reset,
      state_ff == ST_ENC_DIV || state_ff == ST_DEC_MUL, carry_ff < radix_val)
   `RTNC_ASSERT_IMPL(a_digit_count_bound, clock, reset,
      state_ff == ST_ENC_DIV, digit_cnt_ff < DIGIT_IDX_WIDTH'(MAX_DIGITS))
   `RTNC_ASSERT_NEXT(a_acc_cleared, clock, reset,
      state_ff == ST_DEC_OUT && slot_free, acc_ff == '0 && !err_ff)
   `RTNC_ASSERT_IMPL(a_number_beat_no_symbol, clock, reset,
      rsp_valid_ff && rsp_is_number_ff, rsp_symbol_ff == '0 && rsp_last_result_ff)

endmodule
